// ===== rtl/core/rhk_pkg.sv =====
package rhk_pkg;

	localparam int MAX_SLOTS     = 6;
	localparam int KEY_SLOTS_DEF = 6;
	localparam int TABLE_DEF     = 128;
	localparam int QUEUE_DEPTH   = 2;

	localparam int IN_W   = 8 + 8 * MAX_SLOTS;
	localparam int OUT_W  = 16;
	localparam int USER_W = 3;

	// modifier byte masks, left and right halves
	localparam logic [7:0] MOD_CTRL  = 8'h11;
	localparam logic [7:0] MOD_SHIFT = 8'h22;
	localparam logic [7:0] MOD_ALT   = 8'h44;

	localparam logic [7:0] USAGE_DELETE = 8'h4C;
	localparam logic [7:0] USAGE_F1     = 8'h3A;
	localparam logic [7:0] USAGE_F2     = 8'h3B;
	localparam logic [7:0] USAGE_F3     = 8'h3C;

	localparam logic [6:0] CODE_SHIFT_BIT = 7'h40;

	typedef enum logic [2:0] {
		EV_STATUS   = 3'd0,
		EV_KEYCODE  = 3'd1,
		EV_BREAK    = 3'd2,
		EV_RESET    = 3'd3,
		EV_START    = 3'd4,
		EV_SELECT   = 3'd5,
		EV_OPTION   = 3'd6,
		EV_RELEASED = 3'd7
	} ev_kind_t;

	// one classified report, front to back
	typedef struct packed {
		logic [MAX_SLOTS-1:0]        act;
		ev_kind_t [MAX_SLOTS-1:0]    kind;
		logic [MAX_SLOTS-1:0][7:0]   key;
		logic                        shift;
		logic                        any;
	} rhk_entry_t;

	localparam int ROM_DEPTH = 58;

	localparam logic [6:0] PLAIN_ROM [ROM_DEPTH] = '{
		7'h00, 7'h00, 7'h00, 7'h00,
		7'h3F, 7'h15, 7'h12, 7'h3A, 7'h2A, 7'h38, 7'h3D, 7'h39, 7'h0D, 7'h01, 7'h05, 7'h00,
		7'h25, 7'h23, 7'h08, 7'h0A, 7'h2F, 7'h28, 7'h3E, 7'h2D, 7'h0B, 7'h10, 7'h2E, 7'h16,
		7'h2B, 7'h17,
		7'h1F, 7'h1E, 7'h1A, 7'h18, 7'h1D, 7'h1B, 7'h33, 7'h35, 7'h30, 7'h32,
		7'h0C, 7'h1C, 7'h34, 7'h2C, 7'h21, 7'h0E, 7'h0F, 7'h60, 7'h62, 7'h46, 7'h5A, 7'h02,
		7'h73, 7'h00, 7'h20, 7'h22, 7'h26, 7'h3C
	};

	localparam logic [6:0] SHIFTED_ROM [ROM_DEPTH] = '{
		7'h00, 7'h00, 7'h00, 7'h00,
		7'h7F, 7'h55, 7'h52, 7'h3A, 7'h2A, 7'h38, 7'h3D, 7'h39, 7'h0D, 7'h01, 7'h05, 7'h00,
		7'h25, 7'h23, 7'h08, 7'h0A, 7'h2F, 7'h28, 7'h3E, 7'h2D, 7'h0B, 7'h10, 7'h2E, 7'h16,
		7'h2B, 7'h17,
		7'h5F, 7'h75, 7'h5A, 7'h58, 7'h5D, 7'h47, 7'h5B, 7'h07, 7'h70, 7'h72,
		7'h0C, 7'h1C, 7'h34, 7'h2C, 7'h21, 7'h4E, 7'h06, 7'h00, 7'h00, 7'h4F, 7'h5A, 7'h42,
		7'h5E, 7'h00, 7'h36, 7'h37, 7'h66, 7'h3C
	};

	// entries past the listed part of the table are zero
	function automatic logic [6:0] rom_code(input logic [7:0] key, input logic shift);
		logic [6:0] code;
		code = 7'd0;
		if ({1'b0, key} < 9'(ROM_DEPTH)) begin
			code = shift ? SHIFTED_ROM[key[5:0]] : PLAIN_ROM[key[5:0]];
		end
		return code;
	endfunction

endpackage

// ===== rtl/core/rhk_front.sv =====
module rhk_front #(
	parameter int KEY_SLOTS = rhk_pkg::KEY_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [rhk_pkg::IN_W-1:0] in_data,
	output logic                     entry_valid,
	input  logic                     entry_ready,
	output rhk_pkg::rhk_entry_t      entry
);
	import rhk_pkg::*;

	logic [7:0]           prev_keys_q [KEY_SLOTS];
	logic [MAX_SLOTS-1:0][7:0] keys;
	logic [7:0]           mods;
	logic                 ctrl, alt, accept;
	logic [MAX_SLOTS-1:0] fresh;

	assign mods        = in_data[7:0];
	assign ctrl        = |(mods & MOD_CTRL);
	assign alt         = |(mods & MOD_ALT);
	assign in_ready    = entry_ready;
	assign entry_valid = in_valid;
	assign accept      = in_valid && entry_ready;

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			keys[i] = (i < KEY_SLOTS) ? in_data[8*i+8 +: 8] : 8'd0;
		end
		for (int i = 0; i < MAX_SLOTS; i++) begin
			fresh[i] = (keys[i] != 8'd0);
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_keys_q[j] == keys[i]) fresh[i] = 1'b0;
			end
		end
	end

	// per-slot classification; ctrl with an unmapped key yields nothing
	always_comb begin
		entry.key   = keys;
		entry.shift = |(mods & MOD_SHIFT);
		entry.any   = |keys;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			entry.act[i]  = fresh[i];
			entry.kind[i] = EV_KEYCODE;
			if (ctrl) begin
				unique case (keys[i])
					USAGE_DELETE: entry.kind[i] = alt ? EV_RESET : EV_BREAK;
					USAGE_F1:     entry.kind[i] = EV_START;
					USAGE_F2:     entry.kind[i] = EV_SELECT;
					USAGE_F3:     entry.kind[i] = EV_OPTION;
					default: begin
						entry.kind[i] = EV_STATUS;
						entry.act[i]  = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < KEY_SLOTS; j++) prev_keys_q[j] <= 8'd0;
		end else if (accept) begin
			for (int j = 0; j < KEY_SLOTS; j++) prev_keys_q[j] <= keys[j];
		end
	end

endmodule

// ===== rtl/core/rhk_queue.sv =====
module rhk_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  rhk_pkg::rhk_entry_t wr_entry,
	output logic                rd_valid,
	input  logic                rd_ready,
	output rhk_pkg::rhk_entry_t rd_entry
);
	import rhk_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	rhk_entry_t  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, pop;

	assign wr_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_entry = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + (PW+1)'(1);
			else if (pop && !push) count_q <= count_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// ===== rtl/core/rhk_back.sv =====
module rhk_back #(
	parameter int TABLE_ENTRIES = rhk_pkg::TABLE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       entry_valid,
	output logic                       entry_ready,
	input  rhk_pkg::rhk_entry_t        entry,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rhk_pkg::OUT_W-1:0]  out_data,
	output logic [rhk_pkg::USER_W-1:0] out_user,
	output logic                       out_last
);
	import rhk_pkg::*;

	// phase 0: released check, 1..6: slots, 7: closing status
	localparam logic [2:0] PH_RELEASED = 3'd0;
	localparam logic [2:0] PH_STATUS   = 3'd7;

	logic [2:0] phase_q, slot_idx;
	logic       key_down_n_q, shift_n_q;
	logic       kd_nxt, sh_nxt, step, emit;
	ev_kind_t   kind_nxt;
	logic [6:0] code_nxt, lookup;
	logic [7:0] key;

	logic       valid_q, last_q;
	ev_kind_t   kind_q;
	logic [6:0] code_q;
	logic       kd_out_q, sh_out_q;

	assign step        = entry_valid && (!valid_q || out_ready);
	assign entry_ready = step && (phase_q == PH_STATUS);
	assign slot_idx    = (phase_q == PH_RELEASED || phase_q == PH_STATUS) ?
	                     3'd0 : phase_q - 3'd1;
	assign key         = entry.key[slot_idx];
	assign lookup      = ({1'b0, key} < 9'(TABLE_ENTRIES)) ? rom_code(key, entry.shift) : 7'd0;

	always_comb begin
		kd_nxt   = key_down_n_q;
		sh_nxt   = shift_n_q;
		kind_nxt = EV_STATUS;
		code_nxt = 7'd0;
		emit     = 1'b0;
		if (phase_q == PH_RELEASED) begin
			if (!entry.any) begin
				emit     = 1'b1;
				kind_nxt = EV_RELEASED;
				kd_nxt   = 1'b1;
				sh_nxt   = 1'b1;
			end
		end else if (phase_q == PH_STATUS) begin
			emit = 1'b1;
		end else if (entry.act[slot_idx]) begin
			emit     = 1'b1;
			kind_nxt = entry.kind[slot_idx];
			if (entry.kind[slot_idx] == EV_KEYCODE) begin
				code_nxt = lookup;
				kd_nxt   = 1'b0;
				if ((lookup & CODE_SHIFT_BIT) != 7'd0) sh_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RELEASED;
			key_down_n_q <= 1'b1;
			shift_n_q    <= 1'b1;
			valid_q      <= 1'b0;
		end else begin
			if (step) begin
				phase_q      <= phase_q + 3'd1;
				key_down_n_q <= kd_nxt;
				shift_n_q    <= sh_nxt;
			end
			if (step && emit)  valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_q   <= kind_nxt;
			code_q   <= code_nxt;
			kd_out_q <= kd_nxt;
			sh_out_q <= sh_nxt;
			last_q   <= (phase_q == PH_STATUS);
		end
	end

	assign out_valid = valid_q;
	assign out_user  = kind_q;
	assign out_last  = last_q;
	assign out_data  = {(OUT_W-9)'(0), sh_out_q, kd_out_q, code_q};

endmodule

// ===== rtl/core/hid_keyboard_to_retro_keycode.sv =====
// Boot keyboard report to seven-bit key code translator.
// Input channel (s_*): one request per USB boot keyboard report, the
// modifier byte and six key slots. Output channel (m_*): event items,
// the event kind on m_tuser, code and active-low status bits on m_tdata.
// Each report yields an optional released item, one item for every newly
// pressed key (with ctrl held, only keys that map to an event), and always
// a closing status item with m_tlast high.
// Sequencing: the back sequencer walks one phase per cycle while the queue
// holds a report and the output register can take an item (released check,
// six slots, status), through a single table lookup, so items leave in that
// order; a two-entry queue lets the front take the next report while the
// back is still busy.
// Reset: previous keys cleared, both status bits high, queue and output
// register empty.
// Stall: when m_tready is low a held item stays in the output register and
// the sequencer waits; once the queue fills, s_tready drops.
module hid_keyboard_to_retro_keycode #(
	parameter int KEY_SLOTS     = rhk_pkg::KEY_SLOTS_DEF,  // 1..6 slots used
	parameter int TABLE_ENTRIES = rhk_pkg::TABLE_DEF       // 128..256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// modifier_bits, slot0_key .. slot5_key
	input  logic [rhk_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// target_code, key_down_n, shift_down_n, zero pad
	output logic [rhk_pkg::OUT_W-1:0]   m_tdata,
	// event_kind
	output logic [rhk_pkg::USER_W-1:0]  m_tuser,
	output logic                        m_tlast
);
	import rhk_pkg::*;

	rhk_entry_t front_entry, back_entry;
	logic       front_valid, front_ready;
	logic       back_valid, back_ready;

	// front: held-key compare and per-slot classification
	rhk_front #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.entry_valid(front_valid),
		.entry_ready(front_ready),
		.entry      (front_entry)
	);

	// decouples report intake from event emission
	rhk_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.wr_entry(front_entry),
		.rd_valid(back_valid),
		.rd_ready(back_ready),
		.rd_entry(back_entry)
	);

	// back: table lookup, status bits, output register
	rhk_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_valid(back_valid),
		.entry_ready(back_ready),
		.entry      (back_entry),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_user   (m_tuser),
		.out_last   (m_tlast)
	);

endmodule
